FILE: hdl/cirt_pkg.sv
// ----------------------------------------------------------------------------
// Clause ID renumber table package
// Shared command codes and the result beat type.
// ----------------------------------------------------------------------------
package cirt_pkg;

    typedef enum logic [1:0] {
        CMD_PRELOAD = 2'd0,
        CMD_ADD     = 2'd1,
        CMD_HINT    = 2'd2,
        CMD_DELETE  = 2'd3
    } t_cmd;

    localparam logic [31:0] ID_MAX = 32'hFFFF_FFFF;
    localparam logic [31:0] HASH_MULT = 32'd2654435761;

    typedef struct packed {
        logic        counter_saturated;
        logic        table_full;
        logic [31:0] last_used_id;
        logic        found;
        logic [31:0] mapped_id;
    } t_result;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == ID_MAX) ? ID_MAX : v + 32'd1;
    endfunction

endpackage

FILE: hdl/cirt_store.sv
// ----------------------------------------------------------------------------
// Clause ID renumber table store
// Key and value memories, one read port and one write port each, with
// registered read data.
// ----------------------------------------------------------------------------
module cirt_store #(
    parameter int TABLE_DEPTH = 4096,
    parameter int AW = $clog2(TABLE_DEPTH)
) (
    input  logic          i_clk,
    input  logic [AW-1:0] i_rd_addr,
    output logic [32:0]   o_rd_key,
    output logic [31:0]   o_rd_val,
    input  logic          i_wr_key_en,
    input  logic          i_wr_val_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [32:0]   i_wr_key,
    input  logic [31:0]   i_wr_val
);
    logic [32:0] r_keys [TABLE_DEPTH];
    logic [31:0] r_vals [TABLE_DEPTH];

    // Write and read both memories
    always_ff @(posedge i_clk) begin
        if (i_wr_key_en) begin
            r_keys[i_wr_addr] <= i_wr_key;
        end
        if (i_wr_val_en) begin
            r_vals[i_wr_addr] <= i_wr_val;
        end
        o_rd_key <= r_keys[i_rd_addr];
        o_rd_val <= r_vals[i_rd_addr];
    end
endmodule

FILE: hdl/clause_id_renumber_table.sv
// Flow: after the input beat is taken, the hashing states S_HASH1 and S_HASH2, MAX_PROBES
// probe reads (one key read per cycle), a write-back state and an output state that
// registers the counter fields. Input: a new beat is taken only in the idle state, after the
// previous result has been taken; a waiting result holds the input off. Reset: a clearing
// pass walks all TABLE_DEPTH slots, one per cycle, before the first beat; reset sets the
// counter to 1, and a register write sets it to the written value + 1.
// ----------------------------------------------------------------------------
// Clause ID renumber table
// Hash map from old clause ID to new ID with a saturating next-ID counter.
// ----------------------------------------------------------------------------
module clause_id_renumber_table #(
    parameter int TABLE_DEPTH = 4096,
    parameter int MAX_PROBES  = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // old_id[31:0], preload_id[63:32]
    input  logic [63:0]  s_axis_tdata,
    // command[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // mapped_id[31:0], found[32], last_used_id[64:33], table_full[65],
    // counter_saturated[66], zero fill to 72
    output logic [71:0]  m_axis_tdata
);
    import cirt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int PW = $clog2(MAX_PROBES + 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH1, S_HASH2, S_PROBE, S_WRITE, S_OUT
    } t_state;

    t_state        r_state;
    logic [AW:0]   r_clr;
    logic [31:0]   r_next;
    t_cmd          r_cmd;
    logic [31:0]   r_old, r_pre;
    logic [31:0]   r_prod;
    logic [AW-1:0] r_home;
    logic [PW-1:0] r_issue, r_seen;
    logic          r_hit, r_free_ok;
    logic [AW-1:0] r_hit_slot, r_free_slot;
    logic [31:0]   r_hit_val;
    t_result       r_res;
    logic          r_ovalid;

    logic [AW-1:0] w_rd_addr, w_wr_addr, w_seen_slot;
    logic [32:0]   w_rd_key, w_wr_key;
    logic [31:0]   w_rd_val, w_wr_val, w_h;
    logic          w_wr_key_en, w_wr_val_en;

    assign w_h = r_prod ^ {16'd0, r_prod[31:16]};
    assign w_rd_addr = r_home + AW'(r_issue);
    assign w_seen_slot = r_home + AW'(r_seen);

    cirt_store #(.TABLE_DEPTH(TABLE_DEPTH), .AW(AW)) u_store (
        .i_clk       (i_clk),
        .i_rd_addr   (w_rd_addr),
        .o_rd_key    (w_rd_key),
        .o_rd_val    (w_rd_val),
        .i_wr_key_en (w_wr_key_en),
        .i_wr_val_en (w_wr_val_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_key    (w_wr_key),
        .i_wr_val    (w_wr_val)
    );

    // Pick the write-back for the clearing pass or the current command
    always_comb begin
        w_wr_key_en = 1'b0;
        w_wr_val_en = 1'b0;
        w_wr_addr   = r_hit ? r_hit_slot : r_free_slot;
        w_wr_key    = {1'b1, r_old};
        w_wr_val    = (r_cmd == CMD_PRELOAD) ? r_pre : r_next;
        if (r_state == S_CLEAR) begin
            w_wr_key_en = 1'b1;
            w_wr_addr   = r_clr[AW-1:0];
            w_wr_key    = '0;
        end else if (r_state == S_WRITE) begin
            case (r_cmd)
                CMD_PRELOAD, CMD_ADD: begin
                    w_wr_val_en = r_hit || r_free_ok;
                    w_wr_key_en = !r_hit && r_free_ok;
                end
                CMD_DELETE: begin
                    w_wr_key_en = r_hit;
                    w_wr_key    = '0;
                end
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_res};

    // Sequence one command through hash, probe, write-back and output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_next   <= 32'd1;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_next <= sat_inc(i_cfg_wdata);
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + (AW+1)'(1);
                    if (r_clr == (AW+1)'(TABLE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd   <= t_cmd'(s_axis_tuser);
                        r_old   <= s_axis_tdata[31:0];
                        r_pre   <= s_axis_tdata[63:32];
                        r_prod  <= s_axis_tdata[31:0] * HASH_MULT;
                        r_state <= S_HASH1;
                    end
                end
                S_HASH1: begin
                    r_home    <= w_h[AW-1:0];
                    r_issue   <= '0;
                    r_seen    <= '0;
                    r_hit     <= 1'b0;
                    r_free_ok <= 1'b0;
                    r_state   <= S_HASH2;
                end
                S_HASH2: begin
                    r_issue <= r_issue + PW'(1);
                    r_state <= S_PROBE;
                end
                S_PROBE: begin
                    // Examine the slot read last cycle
                    if (w_rd_key == {1'b1, r_old} && !r_hit) begin
                        r_hit      <= 1'b1;
                        r_hit_slot <= w_seen_slot;
                        r_hit_val  <= w_rd_val;
                    end
                    if (!w_rd_key[32] && !r_free_ok) begin
                        r_free_ok   <= 1'b1;
                        r_free_slot <= w_seen_slot;
                    end
                    r_seen  <= r_seen + PW'(1);
                    r_issue <= r_issue + PW'(1);
                    if (r_seen == PW'(MAX_PROBES - 1)) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_res.found <= r_hit;
                    case (r_cmd)
                        CMD_PRELOAD: begin
                            r_res.mapped_id  <= r_pre;
                            r_res.table_full <= !r_hit && !r_free_ok;
                            if (sat_inc(r_pre) > r_next) r_next <= sat_inc(r_pre);
                        end
                        CMD_ADD: begin
                            r_res.mapped_id  <= r_next;
                            r_res.table_full <= !r_hit && !r_free_ok;
                            r_next <= sat_inc(r_next);
                        end
                        CMD_HINT: begin
                            r_res.mapped_id  <= r_hit ? r_hit_val : r_old;
                            r_res.table_full <= 1'b0;
                        end
                        default: begin
                            r_res.mapped_id  <= r_hit ? r_hit_val : 32'd0;
                            r_res.table_full <= 1'b0;
                        end
                    endcase
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_res.last_used_id      <= r_next - 32'd1;
                        r_res.counter_saturated <= (r_next == ID_MAX);
                        r_ovalid <= 1'b1;
                    end else if (m_axis_tready) begin
                        r_ovalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Clause ID renumber table testbench
// Drives preload, add, hint and delete commands into the table and compares
// every result beat with a predictor that keeps its own copy of the key and
// value stores and the next-ID counter. Covers colliding keys that fill a
// probe window, counter saturation, register writes between phases, random
// idling on both sides and one long receiver stall.
// ----------------------------------------------------------------------------
module testbench;
    import cirt_pkg::*;

    localparam int DEPTH      = 4096;
    localparam int PROBES     = 8;
    localparam int IDLE_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // old_id[31:0], preload_id[63:32]
    logic [1:0]  s_axis_tuser = '0;   // command[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;        // mapped_id, found, last_used_id, table_full,
                                      // counter_saturated, zero fill

    clause_id_renumber_table #(.TABLE_DEPTH(DEPTH), .MAX_PROBES(PROBES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state
    bit          slot_valid [DEPTH];
    logic [31:0] slot_key   [DEPTH];
    logic [31:0] slot_value [DEPTH];
    logic [31:0] next_id;
    t_result     pending_results [$];

    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  rx_hold = 1'b0;
    int  mismatches = 0;
    int  idle_cycles = 0;
    int  beats_sent = 0;
    int  beats_checked = 0;
    int  full_seen = 0;
    int  sat_seen = 0;
    logic [31:0] crowded_keys [$];
    logic [31:0] key_pool [64];

    function automatic logic [31:0] sat_next(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic int home_of(input logic [31:0] key);
        logic [63:0] prod;
        logic [31:0] h;
        prod = key * 64'd2654435761;
        h = prod[31:0];
        h = h ^ (h >> 16);
        return int'(h % DEPTH);
    endfunction

    function automatic int locate(input logic [31:0] key);
        int s;
        for (int i = 0; i < PROBES; i++) begin
            s = (home_of(key) + i) % DEPTH;
            if (slot_valid[s] && slot_key[s] == key) return s;
        end
        return -1;
    endfunction

    // Insert or overwrite; returns 0 when the window has no free slot
    function automatic bit store_pair(input logic [31:0] key, input logic [31:0] val,
                                      output bit hit);
        int s;
        s = locate(key);
        hit = (s >= 0);
        if (hit) begin
            slot_value[s] = val;
            return 1'b1;
        end
        for (int i = 0; i < PROBES; i++) begin
            s = (home_of(key) + i) % DEPTH;
            if (!slot_valid[s]) begin
                slot_valid[s] = 1'b1;
                slot_key[s] = key;
                slot_value[s] = val;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_result renumber(input t_cmd cmd, input logic [31:0] old_id,
                                         input logic [31:0] pre_id);
        t_result r;
        bit hit;
        int s;
        r = '0;
        hit = 1'b0;
        case (cmd)
            CMD_PRELOAD: begin
                r.table_full = !store_pair(old_id, pre_id, hit);
                if (sat_next(pre_id) > next_id) next_id = sat_next(pre_id);
                r.mapped_id = pre_id;
            end
            CMD_ADD: begin
                r.mapped_id = next_id;
                r.table_full = !store_pair(old_id, next_id, hit);
                next_id = sat_next(next_id);
            end
            CMD_HINT: begin
                s = locate(old_id);
                hit = (s >= 0);
                r.mapped_id = hit ? slot_value[s] : old_id;
            end
            default: begin
                s = locate(old_id);
                hit = (s >= 0);
                if (hit) begin
                    r.mapped_id = slot_value[s];
                    slot_valid[s] = 1'b0;
                end
            end
        endcase
        r.found = hit;
        r.last_used_id = next_id - 32'd1;
        r.counter_saturated = (next_id == 32'hFFFF_FFFF);
        return r;
    endfunction

    // Receiver: random stalls, plus a hold requested by the backpressure test
    always @(posedge i_clk) begin
        m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Check each result beat against the oldest prediction
    always @(posedge i_clk) begin
        t_result got, want;
        if (m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[66:0]);
            if (pending_results.size() == 0) begin
                $error("unexpected result beat %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                beats_checked++;
                if (got.mapped_id !== want.mapped_id) begin
                    $error("mapped_id exp %h got %h", want.mapped_id, got.mapped_id);
                    mismatches++;
                end
                if (got.found !== want.found) begin
                    $error("found exp %b got %b", want.found, got.found);
                    mismatches++;
                end
                if (got.last_used_id !== want.last_used_id) begin
                    $error("last_used_id exp %h got %h", want.last_used_id, got.last_used_id);
                    mismatches++;
                end
                if (got.table_full !== want.table_full) begin
                    $error("table_full exp %b got %b", want.table_full, got.table_full);
                    mismatches++;
                end
                if (got.counter_saturated !== want.counter_saturated) begin
                    $error("counter_saturated exp %b got %b",
                           want.counter_saturated, got.counter_saturated);
                    mismatches++;
                end
                if (want.table_full) full_seen++;
                if (want.counter_saturated) sat_seen++;
            end
        end
    end

    // Watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_beat(input t_cmd cmd, input logic [31:0] old_id,
                             input logic [31:0] pre_id);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {pre_id, old_id};
        s_axis_tuser <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(renumber(cmd, old_id, pre_id));
        beats_sent++;
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write the register only once the table has drained
    task automatic write_count(input logic [31:0] value);
        stop_sending();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (PROBES + 10) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        next_id = sat_next(value);
    endtask

    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return key_pool[$urandom_range(0, 63)];
        if (r < 75) return crowded_keys[$urandom_range(0, crowded_keys.size() - 1)];
        return $urandom;
    endfunction

    function automatic t_cmd pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return CMD_PRELOAD;
        if (r < 45) return CMD_ADD;
        if (r < 75) return CMD_HINT;
        return CMD_DELETE;
    endfunction

    task automatic test_directed();
        send_beat(CMD_HINT, 32'd0, 32'd0);
        send_beat(CMD_DELETE, 32'hFFFF_FFFF, 32'd0);
        send_beat(CMD_HINT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(CMD_ADD, 32'd0, 32'd0);
        send_beat(CMD_ADD, 32'd0, 32'hFFFF_FFFF);        // overwrite existing key
        send_beat(CMD_HINT, 32'd0, 32'd0);
        send_beat(CMD_PRELOAD, 32'hFFFF_FFFF, 32'd100);  // raise counter
        send_beat(CMD_PRELOAD, 32'hFFFF_FFFF, 32'd5);    // overwrite, counter stays
        send_beat(CMD_ADD, 32'h8000_0000, 32'd0);
        send_beat(CMD_HINT, 32'h8000_0000, 32'd0);
        send_beat(CMD_DELETE, 32'h8000_0000, 32'd0);
        send_beat(CMD_DELETE, 32'h8000_0000, 32'd0);     // already gone
        send_beat(CMD_HINT, 32'hFFFF_FFFF, 32'd0);
        send_beat(CMD_PRELOAD, 32'h1234_5678, 32'hFFFF_FFFE);
        send_beat(CMD_ADD, 32'h5555_5555, 32'd0);        // counter saturates
        send_beat(CMD_ADD, 32'hAAAA_AAAA, 32'd0);        // stays saturated
        send_beat(CMD_DELETE, 32'h5555_5555, 32'd0);
        write_count(32'd0);                              // late write resets counter
        send_beat(CMD_ADD, 32'h0000_0001, 32'd0);
    endtask

    // Fill one probe window with colliding keys, then overflow it
    task automatic test_full_window();
        foreach (crowded_keys[i]) send_beat(CMD_ADD, crowded_keys[i], 32'd0);
        send_beat(CMD_PRELOAD, crowded_keys[PROBES], 32'hFFFF_FFFF);
        write_count(32'd1000);
        send_beat(CMD_DELETE, crowded_keys[2], 32'd0);
        send_beat(CMD_PRELOAD, crowded_keys[PROBES + 1], 32'd7);
        send_beat(CMD_HINT, crowded_keys[PROBES + 1], 32'd0);
        send_beat(CMD_HINT, crowded_keys[PROBES], 32'd0);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_beat(pick_cmd(), pick_key(), $urandom);
    endtask

    // Receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        fork
            begin
                rx_hold = 1'b1;
                repeat (400) @(posedge i_clk);
                rx_hold = 1'b0;
            end
            test_random(60);
        join
    endtask

    initial begin
        int base;
        base = 0;
        for (int i = 0; i < 64; i++) key_pool[i] = $urandom;
        // Collect keys that share the home slot of the first candidate
        for (logic [31:0] k = 32'd1; crowded_keys.size() < PROBES + 2; k++) begin
            if (crowded_keys.size() == 0) begin
                base = home_of(k);
                crowded_keys.push_back(k);
            end else if (home_of(k) == base) begin
                crowded_keys.push_back(k);
            end
        end
        next_id = 32'd1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_full_window();
        tx_idle_pct = 33;
        rx_idle_pct = 54;
        test_random(650);
        write_count(32'hFFFF_FFF0);
        tx_idle_pct = 54;
        rx_idle_pct = 33;
        test_random(650);
        write_count(32'hFFFF_FFFF);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random(100);
        write_count($urandom);
        test_random(550);
        test_backpressure();
        stop_sending();

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (PROBES + 10) @(posedge i_clk);
        $display("covered %0d beats sent, %0d checked", beats_sent, beats_checked);
        $display("dropped inserts %0d, saturated results %0d", full_seen, sat_seen);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
